// ===== src/double_ended_queue_defines.svh =====
// ----------------------------------------------------------------------------
// Deque assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// cons must hold in the same cycle as ante
`define DEQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Shared constants and types of the double-ended queue.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int DATA_W    = 32;
    localparam int ACT_W     = 3;
    localparam int OCC_W     = 7;
    localparam int STAT_W    = 2;
    localparam int OUT_W     = 80;

    localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_PEEK       = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_OUT  = 3'b100
    } deq_state_t;

endpackage

`default_nettype wire

// ===== src/deq_ram.sv =====
// ----------------------------------------------------------------------------
// deq_ram
// Entry store: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ram #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [AW-1:0]              wr_addr,
    input  wire logic [deq_pkg::DATA_W-1:0] wr_data,
    input  wire logic                       rd_en,
    input  wire logic [AW-1:0]              rd_addr_a,
    input  wire logic [AW-1:0]              rd_addr_b,
    output logic      [deq_pkg::DATA_W-1:0] rd_data_a,
    output logic      [deq_pkg::DATA_W-1:0] rd_data_b
);

    logic [deq_pkg::DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

`default_nettype wire

// ===== src/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of 32-bit words kept in a ring of DEPTH entries.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat (s_*): s_tuser carries the action (push front, push back,
//   pop front, pop back, peek), s_tdata the word to push.
//   Output beat (m_*): one per input beat, with front and back words after
//   the operation (-1 when empty), empty flag, occupancy and status
//   (ok, push dropped on full, pop ignored on empty).
//   Timing: an operation runs through accept and pointer/store update,
//   a two-port read of the new front and back entries, then the load of
//   the output register. The single-port-write memory round trip sets
//   this order: a new beat is accepted only once the previous result has
//   been loaded into the output register; m_tvalid rises with that load.
//   The output register lets a new beat be accepted while a result still
//   waits; if m_tready stays low, the next result is held in the read data
//   register and s_tready stays low until the output register frees up.
//   Reset empties the deque (pointers and count to zero); the store itself
//   is not cleared, since only written entries are ever shown.
// ----------------------------------------------------------------------------
`default_nettype none

`include "double_ended_queue_defines.svh"

module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [deq_pkg::DATA_W-1:0] s_tdata,   // [31:0] value
    input  wire logic [deq_pkg::ACT_W-1:0]  s_tuser,   // [2:0] action
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // [31:0] front_value, [63:32] back_value, [64] is_empty,
    // [71:65] occupancy, [73:72] status, [79:74] zero
    output logic      [deq_pkg::OUT_W-1:0]  m_tdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    deq_pkg::deq_state_t state_reg, state_next;

    logic [AW-1:0]                 head_reg, head_next;
    logic [AW-1:0]                 tail_reg, tail_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [deq_pkg::STAT_W-1:0]    status_reg, status_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [deq_pkg::OUT_W-1:0]     out_data_reg, out_data_next;

    logic                          accept;
    logic                          load;
    logic                          full;
    logic                          empty;
    logic [AW-1:0]                 head_prev, head_succ, tail_prev, tail_succ;

    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic                          rd_en;
    logic [deq_pkg::DATA_W-1:0]    rd_front, rd_back;

    logic [CW+deq_pkg::OCC_W-1:0]  count_ext;
    logic                          none_left;
    logic [deq_pkg::DATA_W-1:0]    front_word, back_word;

    // ring neighbors
    assign head_prev = (head_reg == '0) ? LAST_IDX : head_reg - AW'(1);
    assign head_succ = (head_reg == LAST_IDX) ? '0 : head_reg + AW'(1);
    assign tail_prev = (tail_reg == '0) ? LAST_IDX : tail_reg - AW'(1);
    assign tail_succ = (tail_reg == LAST_IDX) ? '0 : tail_reg + AW'(1);

    assign full  = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);

    assign s_tready = (state_reg == deq_pkg::S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign load     = (state_reg == deq_pkg::S_OUT) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        status_next = status_reg;
        wr_en       = 1'b0;
        wr_addr     = tail_reg;
        if (accept)
        begin
            status_next = deq_pkg::ST_OK;
            unique case (s_tuser)
                deq_pkg::ACT_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status_next = deq_pkg::ST_FULL;
                    end
                    else
                    begin
                        head_next  = head_prev;
                        wr_en      = 1'b1;
                        wr_addr    = head_prev;
                        count_next = count_reg + CW'(1);
                    end
                end
                deq_pkg::ACT_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = deq_pkg::ST_FULL;
                    end
                    else
                    begin
                        tail_next  = tail_succ;
                        wr_en      = 1'b1;
                        wr_addr    = tail_reg;
                        count_next = count_reg + CW'(1);
                    end
                end
                deq_pkg::ACT_POP_FRONT:
                begin
                    if (empty)
                    begin
                        status_next = deq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        head_next  = head_succ;
                        count_next = count_reg - CW'(1);
                    end
                end
                deq_pkg::ACT_POP_BACK:
                begin
                    if (empty)
                    begin
                        status_next = deq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        tail_next  = tail_prev;
                        count_next = count_reg - CW'(1);
                    end
                end
                default:
                begin
                    // peek and unused codes change nothing
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            deq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = deq_pkg::S_READ;
                end
            end
            deq_pkg::S_READ:
            begin
                state_next = deq_pkg::S_OUT;
            end
            deq_pkg::S_OUT:
            begin
                if (load)
                begin
                    state_next = deq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = deq_pkg::S_IDLE;
            end
        endcase
    end

    // pointers are already updated when the read is issued, and the write
    // landed at the accepting edge, before the read, so no forwarding is needed
    assign rd_en = (state_reg == deq_pkg::S_READ);

    deq_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (s_tdata),
        .rd_en     (rd_en),
        .rd_addr_a (head_reg),
        .rd_addr_b (tail_prev),
        .rd_data_a (rd_front),
        .rd_data_b (rd_back)
    );

    assign count_ext  = {{deq_pkg::OCC_W{1'b0}}, count_reg};
    assign none_left  = empty;
    assign front_word = none_left ? '1 : rd_front;
    assign back_word  = none_left ? '1 : rd_back;

    always_comb
    begin
        out_data_next = out_data_reg;
        if (load)
        begin
            out_data_next = {6'b0, status_reg, count_ext[deq_pkg::OCC_W-1:0],
                             none_left, back_word, front_word};
        end
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= deq_pkg::S_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            status_reg   <= deq_pkg::ST_OK;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            status_reg   <= status_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;

    `DEQ_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= FULL_CNT, "count above depth")
    `DEQ_ASSERT_SAME(a_ptr_meet, (count_reg == '0) || (count_reg == FULL_CNT),
                     head_reg == tail_reg, "head and tail disagree with count")
    `DEQ_ASSERT_NEXT(a_accept_read, accept, state_reg == deq_pkg::S_READ,
                     "accepted beat did not start a read")
    `DEQ_ASSERT_SAME(a_empty_marker, m_tvalid_reg && out_data_reg[64],
                     out_data_reg[31:0] == '1 && out_data_reg[63:32] == '1,
                     "empty result without -1 words")

endmodule

`default_nettype wire
